FILE: hdl/int_to_padded_decimal_text_unit_macros.svh
// Assertion macros shared by the decimal text unit modules.
// Each module that includes this file must have clk and rst_n in scope.
`ifndef INT_TO_PADDED_DECIMAL_TEXT_UNIT_MACROS_SVH
`define INT_TO_PADDED_DECIMAL_TEXT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while reset is released.
`define IPDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define IPDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IPDT_ASSERT(lbl, prop, msg)
`define IPDT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hdl/ipdt_pkg.sv
// Shared types and constants for the integer to decimal text unit.
// Used by the controller, the datapath and the top level.
package ipdt_pkg;

  localparam int VALUE_W     = 64;
  localparam int FUNC_W      = 3;
  localparam int FW_W        = 6;
  localparam int CHAR_W      = 8;
  localparam int MAX_WIDTH   = 32;
  localparam int BCD_DIGITS  = 20;
  localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);
  localparam int NDIG_W      = $clog2(BCD_DIGITS + 1);
  localparam int REM_W       = $clog2(MAX_WIDTH + 1);
  localparam int STEP_W      = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] PAD_RESET  = 8'h20;

  // Operand size, taken from the upper two bits of the type code.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_sel;
    logic norm_step;
    logic emit_load;
  } ipdt_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic last;
  } ipdt_status_t;

endpackage

FILE: hdl/ipdt_datapath.sv
// Datapath: operand load, shift-and-add-3 binary to BCD conversion,
// digit count and the registered output character. Depends on ipdt_pkg.
`include "int_to_padded_decimal_text_unit_macros.svh"

module ipdt_datapath
  import ipdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ipdt_cmd_t           cmd,
  output ipdt_status_t        status,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [FW_W-1:0]     in_field_width,
  input  logic                cfg_wr_en,
  input  logic [CHAR_W-1:0]   cfg_wr_data,
  output logic [CHAR_W-1:0]   out_char_code,
  output logic                out_last
);

  logic [VALUE_W-1:0]     mag_r;
  logic [3:0]             bcd_r [BCD_DIGITS];
  logic                   neg_r;
  logic [NDIG_W-1:0]      ndig_r;
  logic [REM_W-1:0]       rem_r;
  logic [CHAR_W-1:0]      pad_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;

  logic [VALUE_W-1:0]     mask;
  logic [VALUE_W-1:0]     raw_masked;
  logic                   sign_bit;
  logic [VALUE_W-1:0]     mag_in;
  logic [REM_W-1:0]       width_sat;
  logic [3:0]             adj [BCD_DIGITS];
  logic [REM_W-1:0]       pos;
  logic [DIGIT_IDX_W-1:0] rd_idx;
  logic [3:0]             rd_digit;
  logic [CHAR_W-1:0]      char_nxt;

  // Operand decode, two's complement magnitude and field width saturation.
  always_comb begin
    unique case (in_func[2:1])
      SIZE_8: begin
        mask     = VALUE_W'({8{1'b1}});
        sign_bit = in_value[7];
      end
      SIZE_16: begin
        mask     = VALUE_W'({16{1'b1}});
        sign_bit = in_value[15];
      end
      SIZE_32: begin
        mask     = VALUE_W'({32{1'b1}});
        sign_bit = in_value[31];
      end
      default: begin
        mask     = {VALUE_W{1'b1}};
        sign_bit = in_value[VALUE_W-1];
      end
    endcase
    raw_masked = in_value & mask;
    if (!in_func[0] && sign_bit) begin
      mag_in = ((~raw_masked) + VALUE_W'(1)) & mask;
    end else begin
      mag_in = raw_masked;
    end
    if (in_field_width > FW_W'(MAX_WIDTH)) begin
      width_sat = REM_W'(MAX_WIDTH);
    end else begin
      width_sat = REM_W'(in_field_width);
    end
  end

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  // One digit read port, shared by the digit count and the character output.
  assign pos      = rem_r - REM_W'(1);
  assign rd_idx   = cmd.norm_sel ? DIGIT_IDX_W'(ndig_r - NDIG_W'(1)) :
                                   pos[DIGIT_IDX_W-1:0];
  assign rd_digit = bcd_r[rd_idx];

  assign status.norm_done = (ndig_r == NDIG_W'(1)) || (rd_digit != 4'd0);
  assign status.last      = out_last_r;

  always_comb begin
    if (rem_r == REM_W'(0)) begin
      char_nxt = CHAR_NUL;
    end else if (pos < REM_W'(ndig_r)) begin
      char_nxt = CHAR_ZERO + CHAR_W'(rd_digit);
    end else if (neg_r && (pos == REM_W'(ndig_r))) begin
      char_nxt = CHAR_MINUS;
    end else begin
      char_nxt = pad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= mag_in;
      neg_r  <= !in_func[0] && sign_bit;
      ndig_r <= NDIG_W'(BCD_DIGITS);
      rem_r  <= width_sat;
      for (int i = 0; i < BCD_DIGITS; i++) begin
        bcd_r[i] <= 4'd0;
      end
    end else if (cmd.conv_step) begin
      mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
      bcd_r[0] <= {adj[0][2:0], mag_r[VALUE_W-1]};
      for (int i = 1; i < BCD_DIGITS; i++) begin
        bcd_r[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end else if (cmd.norm_step) begin
      ndig_r <= ndig_r - NDIG_W'(1);
    end else if (cmd.emit_load && (rem_r != REM_W'(0))) begin
      rem_r <= rem_r - REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r      <= PAD_RESET;
      out_char_r <= CHAR_NUL;
      out_last_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pad_r <= cfg_wr_data;
      end
      if (cmd.emit_load) begin
        out_char_r <= char_nxt;
        out_last_r <= (rem_r == REM_W'(0));
      end
    end
  end

  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  `IPDT_ASSERT_ALWAYS(a_last_is_nul, out_last_r |-> (out_char_r == CHAR_NUL), "terminator not NUL")
  `IPDT_ASSERT(a_norm_floor, cmd.norm_step |-> (ndig_r > NDIG_W'(1)), "digit count below one")

endmodule

FILE: hdl/ipdt_ctrl.sv
// Controller state machine: sequences load, conversion, digit count and
// character output. Depends on ipdt_pkg.
`include "int_to_padded_decimal_text_unit_macros.svh"

module ipdt_ctrl
  import ipdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output ipdt_cmd_t    cmd,
  input  ipdt_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_NORM = 5'b00100,
    ST_PREP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_cnt_r, step_cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          step_cnt_nxt = '0;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        step_cnt_nxt  = step_cnt_r + STEP_W'(1);
        if (step_cnt_r == LAST_STEP) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.norm_sel = 1'b1;
        if (status.norm_done) begin
          state_nxt = ST_PREP;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_PREP: begin
        cmd.emit_load = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.emit_load = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  `IPDT_ASSERT(a_one_item, out_valid |-> in_stall, "input taken while output busy")
  `IPDT_ASSERT(a_conv_len, ((state_r == ST_CONV) && (step_cnt_r == LAST_STEP)) |=> (state_r == ST_NORM), "conversion length wrong")
  `IPDT_ASSERT(a_emit_entry, $rose(out_valid) |-> $past(state_r == ST_PREP), "output without first character")

endmodule

FILE: hdl/int_to_padded_decimal_text_unit.sv
// Top level of the integer to right-justified decimal text unit.
// Joins ipdt_ctrl and ipdt_datapath; depends on ipdt_pkg.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_func, in_value, in_field_width
//   out     | output    | out_valid / out_stall | out_char_code, out_last
//   cfg     | input     | cfg_wr_en             | cfg_wr_data (pad character)
//
// An item is loaded, converted in 64 steps of shift-and-add-3, then its
// significant digits (1 to 20) are counted, the first character is loaded
// and min(field_width, 32) + 1 output transfers follow.
// The 64-step conversion loop sets most of the time; one item is in work at a time.
// Reset sets the pad character to a space and returns the controller to idle.
// A stall on the output holds the character register and delays the item.
module int_to_padded_decimal_text_unit
  import ipdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [FW_W-1:0]    in_field_width,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_char_code,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [CHAR_W-1:0]  cfg_wr_data
);

  ipdt_cmd_t    cmd;
  ipdt_status_t status;

  ipdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ipdt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_char_code  (out_char_code),
    .out_last       (out_last)
  );

endmodule
